/* design/shlru_pkg.sv */
// Shared types and constants for the shadow LRU hit profiler.
// Used by the front, back and top-level modules; depends on nothing.
`default_nettype none

package shlru_pkg;

	// Geometry of the two shadow tag stores.
	localparam int NUM_SETS         = 64;
	localparam int NUM_WAYS         = 8;
	localparam int LINE_OFFSET_BITS = 6;

	// Field widths fixed by the interface.
	localparam int ADDR_W = 40;
	localparam int CNT_W  = 20;
	localparam int HPOS_W = 3;

	// Derived widths.
	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int WAY_W  = $clog2(NUM_WAYS);
	localparam int TAG_W  = ADDR_W - LINE_OFFSET_BITS - SET_W;
	localparam int ROWS   = 2 * NUM_SETS;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int TENT_W = TAG_W + 1;
	localparam int TROW_W = NUM_WAYS * TENT_W;
	localparam int CENT_W = 2 * CNT_W;
	localparam int CROW_W = NUM_WAYS * CENT_W;

	// Request queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] PERIOD_RESET = CNT_W'(120000);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_SPLIT_ADDR   = 1'b0,
		REG_CLEAR_PERIOD = 1'b1
	} cfg_reg_t;

	// One classified access request.
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [TAG_W-1:0] tag;
		logic             wb;
		logic             dram;
		logic             cleared;
	} acc_req_t;

	typedef enum logic {
		BK_IDLE,
		BK_CALC
	} back_state_t;

endpackage

`default_nettype wire

/* design/shlru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
`default_nettype none

module shlru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/shlru_front.sv */
// Front part: configuration registers, access counting, address classification
// and the short request queue to the back part. Depends on shlru_pkg.
`default_nettype none

module shlru_front import shlru_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              is_writeback,
	output logic                   q_valid,
	output acc_req_t               q_req,
	input  wire logic              q_pop
);

	logic [ADDR_W-1:0] split_q;
	logic [CNT_W-1:0]  period_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              clr;
	logic              in_acc;
	acc_req_t          req;
	acc_req_t          fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [ADDR_W-LINE_OFFSET_BITS-1:0] line;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q  <= '0;
			period_q <= PERIOD_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SPLIT_ADDR) begin
				split_q <= cfg_data;
			end else begin
				period_q <= cfg_data[CNT_W-1:0];
			end
		end
	end

	// Classify the incoming request.
	always_comb begin
		line        = address[ADDR_W-1:LINE_OFFSET_BITS];
		cnt_nxt     = cnt_q + 1'b1;
		clr         = (cnt_nxt == period_q);
		req.dram    = (address >= split_q);
		req.row     = {req.dram, line[SET_W-1:0]};
		req.tag     = line[SET_W +: TAG_W];
		req.wb      = is_writeback;
		req.cleared = clr;
	end

	assign in_ready = (count_q != QCNT_W'(QDEPTH));
	assign in_acc   = in_valid && in_ready;

	// Access counter; it restarts when a period ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc) begin
			cnt_q <= clr ? '0 : cnt_nxt;
		end
	end

	// Request queue payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fifo_q[wr_ptr_q] <= req;
		end
	end

	// Request queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (in_acc && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !in_acc) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign q_valid = (count_q != '0);
	assign q_req   = fifo_q[rd_ptr_q];

	// The back part only pops a queued request.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");

	// The fill level never exceeds the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH)) else $error("queue overfilled");

endmodule

`default_nettype wire

/* design/shlru_back.sv */
// Back part: row read of tag and counter stores, hit search, counter update,
// LRU rotation, write-back and the result register. Depends on shlru_pkg, shlru_ram.
`default_nettype none

module shlru_back import shlru_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire acc_req_t          q_req,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   hit,
	output logic      [HPOS_W-1:0] hit_position,
	output logic                   is_dram,
	output logic      [CNT_W-1:0]  clean_hits,
	output logic      [CNT_W-1:0]  dirty_hits,
	output logic                   counters_cleared
);

	back_state_t      state_q, state_nxt;
	acc_req_t         item_q;
	logic [ROWS-1:0]  tv_q;
	logic [ROWS-1:0]  cv_q;
	logic [TROW_W-1:0] trow;
	logic [CROW_W-1:0] crow;
	logic [TROW_W-1:0] trow_new;
	logic [CROW_W-1:0] crow_new;
	logic             calc;
	logic             tv_eff;
	logic             cv_eff;
	logic             found;
	logic [WAY_W-1:0] pos;
	logic [TENT_W-1:0] ent [NUM_WAYS];
	logic [CENT_W-1:0] cent [NUM_WAYS];
	logic [TENT_W-1:0] touched;
	logic [CNT_W-1:0] clean_old, dirty_old, clean_new, dirty_new;
	logic             out_valid_q;

	shlru_ram #(.WIDTH(TROW_W), .DEPTH(ROWS)) u_tag_ram (
		.clk   (clk),
		.we    (calc),
		.waddr (item_q.row),
		.wdata (trow_new),
		.re    (q_pop),
		.raddr (q_req.row),
		.rdata (trow)
	);

	shlru_ram #(.WIDTH(CROW_W), .DEPTH(ROWS)) u_cnt_ram (
		.clk   (clk),
		.we    (calc),
		.waddr (item_q.row),
		.wdata (crow_new),
		.re    (q_pop),
		.raddr (q_req.row),
		.rdata (crow)
	);

	// Sequencer: read a row, then update it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		calc      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && (!out_valid_q || out_ready)) begin
					q_pop     = 1'b1;
					state_nxt = BK_CALC;
				end
			end
			BK_CALC: begin
				calc      = 1'b1;
				state_nxt = BK_IDLE;
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_req;
		end
	end

	// Hit search, counter update and rotation of the read row.
	always_comb begin
		tv_eff = tv_q[item_q.row];
		cv_eff = cv_q[item_q.row] && !item_q.cleared;
		for (int w = 0; w < NUM_WAYS; w++) begin
			ent[w]  = tv_eff ? trow[w*TENT_W +: TENT_W] : '0;
			cent[w] = cv_eff ? crow[w*CENT_W +: CENT_W] : '0;
		end
		found = 1'b0;
		pos   = WAY_W'(NUM_WAYS - 1);
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (ent[w][TAG_W-1:0] == item_q.tag) begin
				found = 1'b1;
				pos   = WAY_W'(w);
			end
		end
		clean_old = cent[pos][CNT_W-1:0];
		dirty_old = cent[pos][CENT_W-1:CNT_W];
		if (found) begin
			clean_new = clean_old;
			dirty_new = dirty_old;
			if (ent[pos][TAG_W]) begin
				dirty_new = (dirty_old == CNT_MAX) ? dirty_old : dirty_old + 1'b1;
			end else begin
				clean_new = (clean_old == CNT_MAX) ? clean_old : clean_old + 1'b1;
			end
			touched = {ent[pos][TAG_W] | item_q.wb, item_q.tag};
		end else begin
			clean_new = '0;
			dirty_new = '0;
			touched   = {item_q.wb, item_q.tag};
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (w == 0) begin
				trow_new[w*TENT_W +: TENT_W] = touched;
			end else if (WAY_W'(w) <= pos) begin
				trow_new[w*TENT_W +: TENT_W] = ent[w-1];
			end else begin
				trow_new[w*TENT_W +: TENT_W] = ent[w];
			end
			if (WAY_W'(w) == pos) begin
				crow_new[w*CENT_W +: CENT_W] = {dirty_new, clean_new};
			end else begin
				crow_new[w*CENT_W +: CENT_W] = cent[w];
			end
		end
	end

	// Row valid bits: tags read as zero until written, counters until the next write
	// after a period clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_q <= '0;
			cv_q <= '0;
		end else if (calc) begin
			tv_q[item_q.row] <= 1'b1;
			cv_q <= (item_q.cleared ? '0 : cv_q) | (ROWS'(1) << item_q.row);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (calc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (calc) begin
			hit              <= found;
			hit_position     <= HPOS_W'(pos);
			is_dram          <= item_q.dram;
			clean_hits       <= clean_new;
			dirty_hits       <= dirty_new;
			counters_cleared <= item_q.cleared;
		end
	end

	assign out_valid = out_valid_q;

	// An update always comes in the cycle after a row read.
	a_calc_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		calc |-> $past(q_pop)) else $error("update without row read");

	// An update never overwrites a pending result.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		calc |-> (!out_valid_q || $past(out_ready))) else $error("result overwritten");

endmodule

`default_nettype wire

/* design/hybrid_shadow_lru_hit_profiler_core.sv */
// Top level of the shadow LRU hit profiler for a split DRAM/NVM region.
// Depends on shlru_pkg, shlru_front, shlru_back (and shlru_ram through the back).
//
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
// in       in         in_valid/in_ready      address, is_writeback
// out      out        out_valid/out_ready    hit, hit_position, is_dram, clean_hits,
//                                            dirty_hits, counters_cleared
//
// In the back part each access first reads the set row from the tag and counter RAMs,
// then updates the row and writes it back; a new access is read only after the last is
// written back. The front classifies and queues up to two requests. Reset clears row
// valid bits in flip-flops; there is no clearing pass, and a period-end counter clear
// resets the counter valid bits within the normal update. A stalled output holds the back
// part once the result register is full; the front keeps accepting until the queue fills.
`default_nettype none

module hybrid_shadow_lru_hit_profiler_core import shlru_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [ADDR_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              is_writeback,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   hit,
	output logic      [HPOS_W-1:0] hit_position,
	output logic                   is_dram,
	output logic      [CNT_W-1:0]  clean_hits,
	output logic      [CNT_W-1:0]  dirty_hits,
	output logic                   counters_cleared
);

	logic     q_valid;
	logic     q_pop;
	acc_req_t q_req;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	shlru_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.address      (address),
		.is_writeback (is_writeback),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_pop        (q_pop)
	);

	shlru_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_req            (q_req),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hit              (hit),
		.hit_position     (hit_position),
		.is_dram          (is_dram),
		.clean_hits       (clean_hits),
		.dirty_hits       (dirty_hits),
		.counters_cleared (counters_cleared)
	);

endmodule

`default_nettype wire
